// ===== rtl/qrt_pkg.sv =====
// package for the quorum request tracker: item types, codes and default sizes
// no dependencies
`timescale 1ns / 1ps

package qrt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = 1;
  localparam int QCNT_W          = 2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_REPLY = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_t;

  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;
  localparam logic [1:0] KIND_DELETE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_QUORUM  = 2'd1;
  localparam logic [1:0] CFG_REPLICA = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd10;
  localparam logic [1:0]  QUORUM_RST  = 2'd2;
  localparam logic [1:0]  REPLICA_RST = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] trans_id;
    logic [1:0]  op_kind;
    logic        reply_ok;
    logic [31:0] now_time;
  } in_t;

  typedef struct packed {
    logic [31:0] done_id;
    logic [1:0]  done_kind;
    logic [1:0]  status;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  kind;
    logic [31:0] start;
    logic [1:0]  replies;
    logic        failed;
  } ent_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [1:0]  quorum_count;
    logic [1:0]  replica_count;
  } cfg_t;

  typedef struct packed {
    logic valid;
    in_t  item;
  } qhead_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } bk_state_t;

endpackage

// ===== rtl/quorum_request_tracker.sv =====
// top level of the quorum request tracker: configuration registers, front queue, table walker
// depends on qrt_pkg, qrt_front, qrt_back and qrt_ram
`timescale 1ns / 1ps

// Every accepted start, reply or check item passes through the back end states in order:
// BK_IDLE issues the first table read, BK_SCAN visits one slot per cycle as the walker steps
// through the table memory and its one read port, and BK_FINISH records a new request or
// sends the final result. A check sends one result per retired slot, in slot order, with
// last set on the final one; a stalled result channel holds the walk. A two-entry queue in
// front takes items while the walk runs. Items with the unused command code are dropped on
// entry.

module quorum_request_tracker #(
  parameter int TABLE_DEPTH = qrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qrt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output qrt_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_wdata
);

  qrt_pkg::cfg_t   cfg_r;
  qrt_pkg::qhead_t q_head;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= qrt_pkg::TIMEOUT_RST;
      cfg_r.quorum_count  <= qrt_pkg::QUORUM_RST;
      cfg_r.replica_count <= qrt_pkg::REPLICA_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        qrt_pkg::CFG_TIMEOUT: cfg_r.timeout_ticks <= cfg_wdata;
        qrt_pkg::CFG_QUORUM:  cfg_r.quorum_count  <= cfg_wdata[1:0];
        qrt_pkg::CFG_REPLICA: cfg_r.replica_count <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  qrt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  qrt_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == qrt_pkg::ST_FULL)) |-> out_data.last)
    else $error("table full result without last");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.status == qrt_pkg::ST_OK) ||
                   (out_data.status == qrt_pkg::ST_FAIL) ||
                   (out_data.status == qrt_pkg::ST_FULL)))
    else $error("unused status code on result");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("queue pop while empty");
`endif

endmodule

// ===== rtl/qrt_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module qrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/qrt_front.sv =====
// front end: takes input transfers, drops unused command codes, queues the rest
// depends on qrt_pkg
`timescale 1ns / 1ps

module qrt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qrt_pkg::in_t  in_data,
  output qrt_pkg::qhead_t q_head,
  input  logic          q_pop
);

  qrt_pkg::in_t                q_ent_r [qrt_pkg::QUEUE_DEPTH];
  logic [qrt_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [qrt_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [qrt_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        keep;
  logic                        push;

  assign keep = (in_data.cmd == qrt_pkg::CMD_START) ||
                (in_data.cmd == qrt_pkg::CMD_REPLY) ||
                (in_data.cmd == qrt_pkg::CMD_CHECK);

  assign in_stall = (cnt_r == qrt_pkg::QCNT_W'(qrt_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall && keep;

  always_comb begin
    wr_ptr_nxt = push  ? qrt_pkg::QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? qrt_pkg::QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = qrt_pkg::QCNT_W'(cnt_r + {{(qrt_pkg::QCNT_W-1){1'b0}}, push}
                                        - {{(qrt_pkg::QCNT_W-1){1'b0}}, q_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_ent_r[wr_ptr_r] <= in_data;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = q_ent_r[rd_ptr_r];

endmodule

// ===== rtl/qrt_back.sv =====
// back end: walks the request table once per queued item and drives the result register
// depends on qrt_pkg and qrt_ram
`timescale 1ns / 1ps

module qrt_back #(
  parameter int TABLE_DEPTH = qrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  qrt_pkg::cfg_t   cfg,
  input  qrt_pkg::qhead_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output qrt_pkg::out_t   out_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  qrt_pkg::bk_state_t state_r, state_nxt;

  logic [TABLE_DEPTH-1:0] vld_r;
  logic [IDX_W-1:0]       b_idx_r;
  logic                   dup_r;
  logic                   free_v_r;
  logic [IDX_W-1:0]       free_idx_r;
  logic                   pend_v_r;
  qrt_pkg::out_t          pend_r;
  logic                   out_valid_r;
  qrt_pkg::out_t          out_r;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  qrt_pkg::ent_t          ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [$bits(qrt_pkg::ent_t)-1:0] ram_rdata;

  qrt_pkg::in_t           item;
  qrt_pkg::ent_t          ent;
  qrt_pkg::ent_t          ent_upd;
  qrt_pkg::out_t          res;
  qrt_pkg::out_t          out_load_val;
  logic                   is_start, is_reply, is_check;
  logic                   slot_live, id_hit;
  logic [31:0]            age;
  logic                   fail, succ, retire;
  logic [1:0]             need;
  logic                   out_free;
  logic                   adv;
  logic                   fin_ok;
  logic                   out_load;
  logic                   fin_full;
  logic                   fin_write;

  qrt_ram #(
    .WIDTH($bits(qrt_pkg::ent_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign item     = q_head.item;
  assign ent      = qrt_pkg::ent_t'(ram_rdata);
  assign is_start = (item.cmd == qrt_pkg::CMD_START);
  assign is_reply = (item.cmd == qrt_pkg::CMD_REPLY);
  assign is_check = (item.cmd == qrt_pkg::CMD_CHECK);
  assign out_free = !out_valid_r || !out_stall;

  // slot evaluation
  always_comb begin
    slot_live = vld_r[b_idx_r];
    id_hit    = slot_live && (ent.id == item.trans_id);
    age       = item.now_time - ent.start;
    fail      = ent.failed || (age > {16'd0, cfg.timeout_ticks});
    need      = ((ent.kind == qrt_pkg::KIND_CREATE) || (ent.kind == qrt_pkg::KIND_DELETE)) ?
                cfg.replica_count : cfg.quorum_count;
    succ      = (ent.replies >= need);
    retire    = slot_live && (fail || succ);
    res.done_id   = ent.id;
    res.done_kind = ent.kind;
    res.status    = fail ? qrt_pkg::ST_FAIL : qrt_pkg::ST_OK;
    res.last      = 1'b0;
    ent_upd = ent;
    if (item.reply_ok) begin
      ent_upd.replies = (ent.replies == 2'd3) ? 2'd3 : 2'(ent.replies + 2'd1);
    end else begin
      ent_upd.failed = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qrt_pkg::BK_IDLE: begin
        if (q_head.valid) state_nxt = qrt_pkg::BK_SCAN;
      end
      qrt_pkg::BK_SCAN: begin
        if (adv && (b_idx_r == LAST_IDX)) state_nxt = qrt_pkg::BK_FINISH;
      end
      qrt_pkg::BK_FINISH: begin
        if (fin_ok) state_nxt = qrt_pkg::BK_IDLE;
      end
      default: state_nxt = qrt_pkg::BK_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    adv          = 1'b0;
    fin_ok       = 1'b0;
    fin_full     = 1'b0;
    fin_write    = 1'b0;
    out_load     = 1'b0;
    out_load_val = pend_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = b_idx_r;
    ram_wdata    = ent_upd;
    ram_raddr    = '0;
    unique case (state_r)
      qrt_pkg::BK_IDLE: begin
        ram_raddr = '0;
      end
      qrt_pkg::BK_SCAN: begin
        adv = !(is_check && retire && pend_v_r && !out_free);
        ram_raddr = adv ? IDX_W'(b_idx_r + 1'b1) : b_idx_r;
        if (adv && is_reply && id_hit) ram_we = 1'b1;
        if (adv && is_check && retire && pend_v_r) out_load = 1'b1;
      end
      qrt_pkg::BK_FINISH: begin
        fin_full  = is_start && !dup_r && !free_v_r;
        fin_write = is_start && !dup_r && free_v_r;
        fin_ok    = (fin_full || (is_check && pend_v_r)) ? out_free : 1'b1;
        q_pop     = fin_ok;
        if (fin_ok && fin_write) begin
          ram_we              = 1'b1;
          ram_waddr           = free_idx_r;
          ram_wdata.id        = item.trans_id;
          ram_wdata.kind      = item.op_kind;
          ram_wdata.start     = item.now_time;
          ram_wdata.replies   = 2'd0;
          ram_wdata.failed    = 1'b0;
        end
        if (fin_ok && fin_full) begin
          out_load               = 1'b1;
          out_load_val.done_id   = item.trans_id;
          out_load_val.done_kind = item.op_kind;
          out_load_val.status    = qrt_pkg::ST_FULL;
          out_load_val.last      = 1'b1;
        end else if (fin_ok && is_check && pend_v_r) begin
          out_load          = 1'b1;
          out_load_val.last = 1'b1;
        end
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qrt_pkg::BK_IDLE;
      vld_r       <= '0;
      b_idx_r     <= '0;
      dup_r       <= 1'b0;
      free_v_r    <= 1'b0;
      free_idx_r  <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == qrt_pkg::BK_IDLE) && q_head.valid) begin
        b_idx_r  <= '0;
        dup_r    <= 1'b0;
        free_v_r <= 1'b0;
      end
      if ((state_r == qrt_pkg::BK_SCAN) && adv) begin
        b_idx_r <= IDX_W'(b_idx_r + 1'b1);
        if (is_start && id_hit) dup_r <= 1'b1;
        if (is_start && !slot_live && !free_v_r) begin
          free_v_r   <= 1'b1;
          free_idx_r <= b_idx_r;
        end
        if (is_check && retire) begin
          vld_r[b_idx_r] <= 1'b0;
          pend_v_r       <= 1'b1;
        end
      end
      if ((state_r == qrt_pkg::BK_FINISH) && fin_ok) begin
        if (fin_write) vld_r[free_idx_r] <= 1'b1;
        if (is_check) pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= out_load_val;
    if ((state_r == qrt_pkg::BK_SCAN) && adv && is_check && retire) pend_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for quorum_request_tracker: directed and random transfers,
// expected results from an in-bench model of the request table, random idling on both sides
// depends on qrt_pkg and the quorum_request_tracker rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = qrt_pkg::TABLE_DEPTH_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 8;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  qrt_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  qrt_pkg::out_t out_data;
  logic          cfg_wr_en;
  logic [1:0]    cfg_index;
  logic [15:0]   cfg_wdata;

  quorum_request_tracker #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // table model
  logic        tab_live    [DEPTH];
  logic [31:0] tab_id      [DEPTH];
  logic [1:0]  tab_kind    [DEPTH];
  logic [31:0] tab_start   [DEPTH];
  logic [1:0]  tab_replies [DEPTH];
  logic        tab_failed  [DEPTH];
  logic [15:0] cur_timeout;
  logic [1:0]  cur_quorum;
  logic [1:0]  cur_replica;

  qrt_pkg::out_t pending_done[$];
  int            fail_count;
  int            cycle_count;
  logic [31:0]   clock_now;
  bit            tx_quiet;
  bit            rx_quiet;
  int            hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void add_expected(qrt_pkg::out_t r);
    pending_done.insert(pending_done.size(), r);
  endfunction

  function automatic int find_slot(logic [31:0] id);
    for (int i = 0; i < DEPTH; i++) begin
      if (tab_live[i] && tab_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void track_request(qrt_pkg::in_t it);
    int            slot;
    logic [31:0]   age;
    logic [1:0]    need;
    qrt_pkg::out_t res;
    qrt_pkg::out_t held;
    bit            have_held;
    slot = -1;
    have_held = 1'b0;
    held = '0;
    unique case (it.cmd)
      qrt_pkg::CMD_START: begin
        if (find_slot(it.trans_id) < 0) begin
          for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!tab_live[i]) slot = i;
          end
          if (slot < 0) begin
            res.done_id = it.trans_id;
            res.done_kind = it.op_kind;
            res.status = qrt_pkg::ST_FULL;
            res.last = 1'b1;
            add_expected(res);
          end else begin
            tab_live[slot] = 1'b1;
            tab_id[slot] = it.trans_id;
            tab_kind[slot] = it.op_kind;
            tab_start[slot] = it.now_time;
            tab_replies[slot] = 2'd0;
            tab_failed[slot] = 1'b0;
          end
        end
      end
      qrt_pkg::CMD_REPLY: begin
        slot = find_slot(it.trans_id);
        if (slot >= 0) begin
          if (!it.reply_ok) tab_failed[slot] = 1'b1;
          else if (tab_replies[slot] != 2'd3) tab_replies[slot] = tab_replies[slot] + 2'd1;
        end
      end
      qrt_pkg::CMD_CHECK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tab_live[i]) begin
            age = it.now_time - tab_start[i];
            need = (tab_kind[i] == qrt_pkg::KIND_CREATE ||
                    tab_kind[i] == qrt_pkg::KIND_DELETE) ? cur_replica : cur_quorum;
            res.done_id = tab_id[i];
            res.done_kind = tab_kind[i];
            res.last = 1'b0;
            if (tab_failed[i] || age > {16'd0, cur_timeout}) res.status = qrt_pkg::ST_FAIL;
            else res.status = qrt_pkg::ST_OK;
            if (res.status == qrt_pkg::ST_FAIL || tab_replies[i] >= need) begin
              if (have_held) add_expected(held);
              held = res;
              have_held = 1'b1;
              tab_live[i] = 1'b0;
            end
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          add_expected(held);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic qrt_pkg::in_t pack_request(logic [1:0] cmd, logic [31:0] id,
                                                logic [1:0] kind, logic ok,
                                                logic [31:0] now);
    qrt_pkg::in_t it;
    it.cmd = cmd;
    it.trans_id = id;
    it.op_kind = kind;
    it.reply_ok = ok;
    it.now_time = now;
    return it;
  endfunction

  function automatic logic [31:0] live_id_or_random();
    int n_live;
    int pick;
    n_live = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tab_live[i]) n_live++;
    end
    if (n_live == 0) return $urandom;
    pick = $urandom_range(0, n_live - 1);
    for (int i = 0; i < DEPTH; i++) begin
      if (tab_live[i]) begin
        if (pick == 0) return tab_id[i];
        pick--;
      end
    end
    return $urandom;
  endfunction

  // one input transfer; valid stays high afterwards until the next call or release_input
  task automatic send_item(qrt_pkg::in_t it);
    if (!tx_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    track_request(it);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    release_input();
    while (pending_done.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unique case (idx)
      qrt_pkg::CFG_TIMEOUT: cur_timeout = val;
      qrt_pkg::CFG_QUORUM:  cur_quorum = val[1:0];
      qrt_pkg::CFG_REPLICA: cur_replica = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(logic [15:0] tmo, logic [1:0] quorum, logic [1:0] replica);
    wait_idle();
    write_reg(qrt_pkg::CFG_TIMEOUT, tmo);
    write_reg(qrt_pkg::CFG_QUORUM, {14'd0, quorum});
    write_reg(qrt_pkg::CFG_REPLICA, {14'd0, replica});
  endtask

  // mostly well-formed traffic against live ids, some unknown ids and unused codes
  task automatic rand_traffic(int n_items, int max_step);
    int          roll;
    int          sent;
    logic [31:0] id;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_item(pack_request(CMD_UNUSED, $urandom, 2'($urandom), 1'($urandom),
                               $urandom));
      end else if (roll < 42) begin
        id = ($urandom_range(0, 99) < 10) ? live_id_or_random() : $urandom;
        send_item(pack_request(qrt_pkg::CMD_START, id, 2'($urandom), 1'($urandom),
                               clock_now));
        sent++;
      end else if (roll < 86) begin
        id = ($urandom_range(0, 99) < 85) ? live_id_or_random() : $urandom;
        send_item(pack_request(qrt_pkg::CMD_REPLY, id, 2'($urandom),
                               $urandom_range(0, 99) < 85, $urandom));
        sent++;
      end else begin
        send_item(pack_request(qrt_pkg::CMD_CHECK, $urandom, 2'($urandom), 1'($urandom),
                               clock_now));
        sent++;
      end
      clock_now = clock_now + $urandom_range(0, max_step);
    end
  endtask

  // directed: fill every slot near the top of the time range, then a duplicate and a full start
  task automatic test_table_full();
    for (int i = 0; i < DEPTH; i++) begin
      send_item(pack_request(qrt_pkg::CMD_START, i * 32'h1111_1111, i[1:0], 1'b0,
                             32'hFFFF_FFFE));
    end
    send_item(pack_request(qrt_pkg::CMD_START, 32'h3333_3333, qrt_pkg::KIND_READ, 1'b0,
                           32'h0000_0000));
    send_item(pack_request(qrt_pkg::CMD_START, 32'h8000_0001, qrt_pkg::KIND_DELETE, 1'b1,
                           32'hFFFF_FFFF));
  endtask

  // directed: saturating count, failure after quorum, unknown id, unused code
  task automatic test_reply_counting();
    repeat (4) send_item(pack_request(qrt_pkg::CMD_REPLY, 32'h0, qrt_pkg::KIND_CREATE,
                                      1'b1, 32'h0));
    send_item(pack_request(qrt_pkg::CMD_REPLY, 32'h2222_2222, qrt_pkg::KIND_CREATE, 1'b1,
                           32'h0));
    send_item(pack_request(qrt_pkg::CMD_REPLY, 32'h2222_2222, qrt_pkg::KIND_CREATE, 1'b1,
                           32'h0));
    send_item(pack_request(qrt_pkg::CMD_REPLY, 32'h2222_2222, qrt_pkg::KIND_CREATE, 1'b0,
                           32'h0));
    send_item(pack_request(qrt_pkg::CMD_REPLY, 32'h0000_DEAD, qrt_pkg::KIND_READ, 1'b1,
                           32'h0));
    send_item(pack_request(CMD_UNUSED, 32'hFFFF_FFFF, qrt_pkg::KIND_DELETE, 1'b1,
                           32'hFFFF_FFFF));
  endtask

  // directed: age wraps past zero; retire by count, by failure, by timeout, then nothing left
  task automatic test_check_retire();
    send_item(pack_request(qrt_pkg::CMD_CHECK, 32'h0, qrt_pkg::KIND_CREATE, 1'b0, 32'd3));
    send_item(pack_request(qrt_pkg::CMD_CHECK, 32'h0, qrt_pkg::KIND_CREATE, 1'b0, 32'd9));
    send_item(pack_request(qrt_pkg::CMD_CHECK, 32'h0, qrt_pkg::KIND_CREATE, 1'b0, 32'd10));
  endtask

  task automatic test_long_timeout();
    set_limits(16'hFFFF, 2'd3, 2'd3);
    clock_now = $urandom;
    rand_traffic(24, 3);
  endtask

  task automatic test_zero_timeout();
    set_limits(16'd0, 2'd1, 2'd1);
    rand_traffic(20, 1);
  endtask

  task automatic test_zero_quorum_wrap();
    set_limits(16'd20, 2'd0, 2'd2);
    clock_now = 32'hFFFF_FF80;
    rand_traffic(20, 6);
  endtask

  task automatic test_steady_stream();
    set_limits(16'd8, 2'd2, 2'd3);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    rand_traffic(28, 2);
    wait_idle();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // receiver holds off while checks and starts keep arriving
  task automatic test_result_backpressure();
    set_limits(16'd5, 2'd1, 2'd1);
    send_item(pack_request(qrt_pkg::CMD_CHECK, 32'h0, qrt_pkg::KIND_CREATE, 1'b0,
                           clock_now + 32'd1000));
    clock_now = clock_now + 32'd1000;
    for (int i = 0; i < 12; i++) begin
      send_item(pack_request(qrt_pkg::CMD_START, $urandom, 2'($urandom), 1'b0, clock_now));
      if (i % 3 == 0) send_item(pack_request(qrt_pkg::CMD_REPLY, live_id_or_random(),
                                             2'($urandom), 1'b1, $urandom));
    end
    hold_left = HOLD_CYCLES;
    send_item(pack_request(qrt_pkg::CMD_CHECK, $urandom, 2'($urandom), 1'b0,
                           clock_now + 32'd2));
    send_item(pack_request(qrt_pkg::CMD_CHECK, $urandom, 2'($urandom), 1'b0,
                           clock_now + 32'd9));
    rand_traffic(6, 4);
  endtask

  // sender stops until every result has come, several times over
  task automatic test_sender_pause();
    set_limits(16'd12, 2'd2, 2'd2);
    repeat (3) begin
      rand_traffic(7, 3);
      send_item(pack_request(qrt_pkg::CMD_CHECK, $urandom, 2'($urandom), 1'b0,
                             clock_now + 32'd40));
      clock_now = clock_now + 32'd40;
      wait_idle();
    end
  endtask

  // result side stall
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    qrt_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_done.size() == 0) begin
        $error("unexpected result transfer: done_id %h status %0d", out_data.done_id,
               out_data.status);
        fail_count++;
      end else begin
        want = pending_done.pop_front();
        if (out_data.done_id !== want.done_id) begin
          $error("done_id: expected %h, got %h", want.done_id, out_data.done_id);
          fail_count++;
        end
        if (out_data.done_kind !== want.done_kind) begin
          $error("done_kind: expected %0d, got %0d", want.done_kind, out_data.done_kind);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= qrt_pkg::CFG_TIMEOUT;
    cfg_wdata <= '0;
    out_stall <= 1'b0;
    fail_count = 0;
    hold_left = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    clock_now = 32'd0;
    cur_timeout = qrt_pkg::TIMEOUT_RST;
    cur_quorum = qrt_pkg::QUORUM_RST;
    cur_replica = qrt_pkg::REPLICA_RST;
    for (int i = 0; i < DEPTH; i++) begin
      tab_live[i] = 1'b0;
      tab_id[i] = '0;
      tab_kind[i] = '0;
      tab_start[i] = '0;
      tab_replies[i] = '0;
      tab_failed[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_table_full();
    test_reply_counting();
    test_check_retire();
    test_long_timeout();
    test_zero_timeout();
    test_zero_quorum_wrap();
    test_steady_stream();
    test_result_backpressure();
    test_sender_pause();

    wait_idle();
    if (pending_done.size() != 0) begin
      $error("%0d expected results never arrived", pending_done.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qrt_pkg.sv
rtl/qrt_ram.sv
rtl/qrt_front.sv
rtl/qrt_back.sv
rtl/quorum_request_tracker.sv
tb/tb_top.sv
